// File: rtl/core/ctl_pkg.sv
// Shared types, constants and keyword/operator helpers for the C token lexer.
`default_nettype none
package ctl_pkg;

   localparam int KwChars  = 8;
   localparam int LineBits = 16;
   localparam int ColBits  = 12;
   localparam int LenBits  = 12;
   localparam int NumKw    = 32;

   localparam logic [LineBits-1:0] LineSat = {LineBits{1'b1}};
   localparam logic [ColBits-1:0]  ColSat  = {ColBits{1'b1}};
   localparam logic [LenBits-1:0]  LenSat  = {LenBits{1'b1}};

   // token kinds
   localparam logic [5:0] KindEnd    = 6'd0;
   localparam logic [5:0] KindIdent  = 6'd1;
   localparam logic [5:0] KindInt    = 6'd2;
   localparam logic [5:0] KindFloat  = 6'd3;
   localparam logic [5:0] KindString = 6'd4;
   localparam logic [5:0] KindError  = 6'd5;
   localparam logic [5:0] KindPunct  = 6'd6;
   localparam logic [5:0] KindNone   = 6'd0;
   localparam logic [5:0] KindKwBase = 6'd18;

   // diagnostics
   localparam logic [2:0] DiagNone    = 3'd0;
   localparam logic [2:0] DiagBadHex  = 3'd1;
   localparam logic [2:0] DiagEmptyHx = 3'd2;
   localparam logic [2:0] DiagBadOct  = 3'd3;
   localparam logic [2:0] DiagIllegal = 3'd4;
   localparam logic [2:0] DiagOvf     = 3'd5;
   localparam logic [2:0] DiagUnterm  = 3'd6;

   // digit error codes held while scanning a number
   localparam logic [1:0] DerrNone = 2'd0;
   localparam logic [1:0] DerrHex  = 2'd1;
   localparam logic [1:0] DerrOct  = 2'd2;

   // keywords, right aligned, first character in the highest used byte
   localparam logic [63:0] KwText [NumKw] = '{
      "auto", "break", "case", "char", "const", "continue", "default", "do",
      "double", "else", "enum", "extern", "float", "for", "goto", "if",
      "int", "long", "register", "return", "short", "signed", "sizeof", "static",
      "struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"};

   typedef logic [KwChars-1:0][7:0] kw_buf_type;

   typedef struct packed {
      logic [5:0]          kind;
      logic [7:0]          punct_char;
      logic [63:0]         number_value;
      logic [LineBits-1:0] token_line;
      logic [ColBits-1:0]  token_col;
      logic [LenBits-1:0]  token_len;
      logic [2:0]          diag;
      logic                last_of_step;
   } rsp_item_type;

   function automatic logic is_digit(logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] b);
      return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
   endfunction

   // two-character operator kind, zero when the pair is no operator
   function automatic logic [5:0] pair_kind(logic [7:0] a, logic [7:0] b);
      logic [5:0] k;
      k = KindNone;
      unique case (a)
         "+": if (b == "+") k = 6'd7;
         "-": if (b == ">") k = 6'd8; else if (b == "-") k = 6'd9;
         "<": if (b == "=") k = 6'd10; else if (b == "<") k = 6'd11;
         ">": if (b == "=") k = 6'd12; else if (b == ">") k = 6'd13;
         "=": if (b == "=") k = 6'd14;
         "|": if (b == "|") k = 6'd15;
         "&": if (b == "&") k = 6'd16;
         "!": if (b == "=") k = 6'd17;
         default: k = KindNone;
      endcase
      return k;
   endfunction

   // identifier or keyword kind for a run of n characters held in kw
   function automatic logic [5:0] ident_kind(kw_buf_type kw, logic [LenBits-1:0] n);
      logic [5:0]  k;
      logic [3:0]  len;
      logic        ok;
      logic [2:0]  p;
      k = KindIdent;
      if (n <= LenBits'(KwChars)) begin
         for (int e = 0; e < NumKw; e++) begin
            len = 4'd0;
            for (int j = 0; j < 8; j++)
               if (KwText[e][8*j +: 8] != 8'd0) len = len + 4'd1;
            ok = ({8'd0, len} == n);
            for (int i = 0; i < KwChars; i++) begin
               p = 3'(len - 4'd1 - 4'(i));
               if ((LenBits'(i) < n) && (kw[i] != KwText[e][8*p +: 8])) ok = 1'b0;
            end
            if (ok && (k == KindIdent)) k = KindKwBase + 6'(e);
         end
      end
      return k;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/c_token_lexer_core.sv
// Top level of the C token lexer: byte scanner with a small result queue.
`default_nettype none
// Channel | Dir | Ports                         | Content
// req     | in  | req_tvalid/tready/tdata[7:0]  | src_byte
// rsp     | out | rsp_tvalid/tready/tdata/tuser | one token, tlast = last of its byte
//
// Each source byte is scanned in the cycle it is accepted; its results (zero,
// one or two tokens) are registered into a four-entry queue and leave one per
// cycle. A byte is taken every cycle while at least two queue slots are free,
// so throughput is one byte per cycle unless bytes produce two tokens in a row
// or the consumer stalls. Synchronous active-high reset clears the scanner to
// idle at line 1, column 0 and empties the queue.
module c_token_lexer_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] src_byte
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [119:0] rsp_tdata,   // punct_char, number_value, token_line,
                                          // token_col, token_len, diag, zero pad
   output      logic [5:0]   rsp_tuser,   // kind
   output      logic         rsp_tlast    // last_of_step
);

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_OCT, M_DEC, M_HEX, M_FLOAT, M_DOT, M_OP,
      M_STR, M_CHR, M_BCOM, M_LCOM
   } mode_type;

   localparam int LB = ctl_pkg::LineBits;
   localparam int CB = ctl_pkg::ColBits;
   localparam int NB = ctl_pkg::LenBits;

   // scanner state
   mode_type            mode_ff, mode_in;
   logic [7:0]          pend_ff, pend_in;
   logic [63:0]         acc_ff, acc_in;
   logic                ovf_ff, ovf_in;
   logic [1:0]          derr_ff, derr_in;
   ctl_pkg::kw_buf_type kw_ff, kw_in;
   logic [NB-1:0]       run_ff, run_in;
   logic [LB-1:0]       sline_ff, sline_in;
   logic [CB-1:0]       scol_ff, scol_in;
   logic [LB-1:0]       line_ff, line_in;
   logic [CB-1:0]       col_ff, col_in;

   // result queue
   ctl_pkg::rsp_item_type q_ff [4];
   logic [1:0]          wptr_ff, rptr_ff;
   logic [2:0]          cnt_ff;

   ctl_pkg::rsp_item_type res [2];
   logic [1:0]          nres;

   logic        req_acc, rsp_acc;
   logic [7:0]  b;
   logic        do_start;
   logic [5:0]  e_kind;
   logic [7:0]  e_punct;
   logic [63:0] e_val;
   logic [2:0]  e_diag;
   logic        e_valid;
   logic [67:0] dec_prod;
   logic [3:0]  dig;
   logic [3:0]  hexd;
   logic        hex_ok;
   logic [5:0]  pk;
   logic [7:0]  quote;

   assign req_tready = (cnt_ff <= 3'd2);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign b          = req_tdata;

   always_comb begin
      mode_in  = mode_ff;  pend_in  = pend_ff;  acc_in  = acc_ff;
      ovf_in   = ovf_ff;   derr_in  = derr_ff;  kw_in   = kw_ff;
      run_in   = run_ff;   sline_in = sline_ff; scol_in = scol_ff;
      line_in  = line_ff;  col_in   = col_ff;
      do_start = 1'b0;
      e_valid  = 1'b0; e_kind = ctl_pkg::KindNone; e_punct = 8'd0;
      e_val    = 64'd0; e_diag = ctl_pkg::DiagNone;
      res[0]   = '0; res[1] = '0; nres = 2'd0;
      dig      = 4'(b - "0");
      dec_prod = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + 68'(dig);
      hex_ok   = 1'b1;
      hexd     = 4'd0;
      if (ctl_pkg::is_digit(b)) hexd = dig;
      else if (b >= "a" && b <= "f") hexd = 4'(b - "a" + 8'd10);
      else if (b >= "A" && b <= "F") hexd = 4'(b - "A" + 8'd10);
      else hex_ok = 1'b0;
      pk    = ctl_pkg::pair_kind(pend_ff, b);
      quote = (mode_ff == M_STR) ? "\"" : "'";

      // advance the token in progress
      unique case (mode_ff)
         M_IDENT: begin
            if (ctl_pkg::is_alpha(b) || ctl_pkg::is_digit(b)) begin
               if (run_ff < NB'(ctl_pkg::KwChars)) kw_in[run_ff[2:0]] = b;
               if (run_ff < ctl_pkg::LenSat) run_in = run_ff + 1'b1;
            end else begin
               e_valid = 1'b1; e_kind = ctl_pkg::ident_kind(kw_ff, run_ff);
               do_start = 1'b1;
            end
         end
         M_OCT: begin
            if (run_ff == NB'(1) && (b == "x" || b == "X")) begin
               mode_in = M_HEX;
               if (run_ff < ctl_pkg::LenSat) run_in = run_ff + 1'b1;
            end else if (run_ff == NB'(1) && b == ".") begin
               mode_in = M_FLOAT;
               if (run_ff < ctl_pkg::LenSat) run_in = run_ff + 1'b1;
            end else if (ctl_pkg::is_digit(b)) begin
               if (dig > 4'd7) derr_in = ctl_pkg::DerrOct;
               if (acc_ff[63:61] != 3'd0) ovf_in = 1'b1;
               else acc_in = (acc_ff << 3) + 64'(dig);
               if (run_ff < ctl_pkg::LenSat) run_in = run_ff + 1'b1;
            end else begin
               e_valid = 1'b1; e_kind = ctl_pkg::KindInt; e_val = acc_ff;
               e_diag = (derr_ff != ctl_pkg::DerrNone) ? ctl_pkg::DiagBadOct :
                        (ovf_ff ? ctl_pkg::DiagOvf : ctl_pkg::DiagNone);
               do_start = 1'b1;
            end
         end
         M_DEC: begin
            if (ctl_pkg::is_digit(b)) begin
               if (dec_prod[67:64] != 4'd0) ovf_in = 1'b1;
               else acc_in = dec_prod[63:0];
               if (run_ff < ctl_pkg::LenSat) run_in = run_ff + 1'b1;
            end else if (b == ".") begin
               mode_in = M_FLOAT;
               if (run_ff < ctl_pkg::LenSat) run_in = run_ff + 1'b1;
            end else begin
               e_valid = 1'b1; e_kind = ctl_pkg::KindInt; e_val = acc_ff;
               e_diag = ovf_ff ? ctl_pkg::DiagOvf : ctl_pkg::DiagNone;
               do_start = 1'b1;
            end
         end
         M_HEX: begin
            if (ctl_pkg::is_alpha(b) || ctl_pkg::is_digit(b)) begin
               if (!hex_ok) derr_in = ctl_pkg::DerrHex;
               else if (acc_ff[63:60] != 4'd0) ovf_in = 1'b1;
               else acc_in = (acc_ff << 4) | 64'(hexd);
               if (run_ff < ctl_pkg::LenSat) run_in = run_ff + 1'b1;
            end else begin
               e_valid = 1'b1;
               if (run_ff == NB'(2)) begin
                  e_kind = ctl_pkg::KindError; e_diag = ctl_pkg::DiagEmptyHx;
               end else if (derr_ff != ctl_pkg::DerrNone) begin
                  e_kind = ctl_pkg::KindError; e_val = acc_ff; e_diag = ctl_pkg::DiagBadHex;
               end else begin
                  e_kind = ctl_pkg::KindInt; e_val = acc_ff;
                  e_diag = ovf_ff ? ctl_pkg::DiagOvf : ctl_pkg::DiagNone;
               end
               do_start = 1'b1;
            end
         end
         M_FLOAT: begin
            if (ctl_pkg::is_digit(b)) begin
               if (run_ff < ctl_pkg::LenSat) run_in = run_ff + 1'b1;
            end else begin
               e_valid = 1'b1; e_kind = ctl_pkg::KindFloat; e_val = acc_ff;
               e_diag = ovf_ff ? ctl_pkg::DiagOvf : ctl_pkg::DiagNone;
               do_start = 1'b1;
            end
         end
         M_DOT: begin
            if (ctl_pkg::is_digit(b)) begin
               mode_in = M_FLOAT; acc_in = 64'd0;
               if (run_ff < ctl_pkg::LenSat) run_in = run_ff + 1'b1;
            end else begin
               e_valid = 1'b1; e_kind = ctl_pkg::KindPunct; e_punct = ".";
               do_start = 1'b1;
            end
         end
         M_OP: begin
            if (pend_ff == "/" && b == "*") begin
               mode_in = M_BCOM; pend_in = 8'd0;
               if (run_ff < ctl_pkg::LenSat) run_in = run_ff + 1'b1;
            end else if (pend_ff == "/" && b == "/") begin
               mode_in = M_LCOM;
            end else if (pk != ctl_pkg::KindNone) begin
               run_in = NB'(2); e_valid = 1'b1; e_kind = pk; mode_in = M_IDLE;
            end else begin
               e_valid = 1'b1; e_kind = ctl_pkg::KindPunct; e_punct = pend_ff;
               do_start = 1'b1;
            end
         end
         M_STR, M_CHR: begin
            if (b == 8'd0) begin
               e_valid = 1'b1; e_kind = ctl_pkg::KindError; e_diag = ctl_pkg::DiagUnterm;
               do_start = 1'b1;
            end else begin
               if (run_ff < ctl_pkg::LenSat) run_in = run_ff + 1'b1;
               if (pend_ff == "\\") pend_in = 8'd0;
               else if (b == "\\") pend_in = "\\";
               else if (b == quote) begin
                  e_valid = 1'b1; e_kind = ctl_pkg::KindString; mode_in = M_IDLE;
               end
            end
         end
         M_BCOM: begin
            if (b == 8'd0) begin
               e_valid = 1'b1; e_kind = ctl_pkg::KindError; e_diag = ctl_pkg::DiagUnterm;
               do_start = 1'b1;
            end else begin
               if (run_ff < ctl_pkg::LenSat) run_in = run_ff + 1'b1;
               if (pend_ff == "*" && b == "/") mode_in = M_IDLE;
               else pend_in = (b == "*") ? "*" : 8'd0;
            end
         end
         M_LCOM: begin
            if (b == 8'd0 || b == "\n") do_start = 1'b1;
         end
         default: do_start = 1'b1;
      endcase

      if (e_valid) begin
         res[0] = '{kind: e_kind, punct_char: e_punct, number_value: e_val,
                    token_line: sline_ff, token_col: scol_ff, token_len: run_in,
                    diag: e_diag, last_of_step: 1'b0};
         nres = 2'd1;
      end

      // open a new token with this byte
      if (do_start) begin
         mode_in = M_IDLE; sline_in = line_ff; scol_in = col_ff; run_in = NB'(1);
         acc_in = 64'd0; ovf_in = 1'b0; derr_in = ctl_pkg::DerrNone; pend_in = 8'd0;
         e_valid = 1'b0; e_kind = ctl_pkg::KindNone; e_punct = 8'd0;
         e_diag = ctl_pkg::DiagNone;
         if (b == 8'd0) begin
            run_in = NB'(0); e_valid = 1'b1; e_kind = ctl_pkg::KindEnd;
            line_in = LB'(1); col_in = CB'(0);
         end else if (b == " " || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == "\n" ||
                      b == "\r" || b == "#" || b == "\\") begin
            mode_in = M_IDLE;
         end else if (ctl_pkg::is_alpha(b)) begin
            mode_in = M_IDENT; kw_in[0] = b;
         end else if (b == "0") begin
            mode_in = M_OCT;
         end else if (ctl_pkg::is_digit(b)) begin
            mode_in = M_DEC; acc_in = 64'(dig);
         end else if (b == ".") begin
            mode_in = M_DOT;
         end else if (b == "\"") begin
            mode_in = M_STR;
         end else if (b == "'") begin
            mode_in = M_CHR;
         end else if (b == "/" || b == "+" || b == "-" || b == "<" || b == ">" ||
                      b == "=" || b == "|" || b == "&" || b == "!") begin
            mode_in = M_OP; pend_in = b;
         end else if (b == ";" || b == "," || b == ":" || b == "*" || b == "~" ||
                      b == "%" || b == "^" || b == "?" || b == "[" || b == "]" ||
                      b == "{" || b == "}" || b == "(" || b == ")") begin
            e_valid = 1'b1; e_kind = ctl_pkg::KindPunct; e_punct = b;
         end else begin
            e_valid = 1'b1; e_kind = ctl_pkg::KindError; e_diag = ctl_pkg::DiagIllegal;
         end
         if (e_valid) begin
            res[nres[0]] = '{kind: e_kind, punct_char: e_punct, number_value: 64'd0,
                             token_line: sline_in, token_col: scol_in, token_len: run_in,
                             diag: e_diag, last_of_step: 1'b0};
            nres = nres + 2'd1;
         end
      end

      // advance the position
      if (b == "\n" || b == "\r") begin
         if (line_in < ctl_pkg::LineSat) line_in = line_in + 1'b1;
         col_in = CB'(0);
      end else if (b != 8'd0) begin
         if (col_in < ctl_pkg::ColSat) col_in = col_in + 1'b1;
      end

      if (nres == 2'd1) res[0].last_of_step = 1'b1;
      if (nres == 2'd2) res[1].last_of_step = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;  pend_ff  <= 8'd0;  acc_ff  <= 64'd0;
         ovf_ff   <= 1'b0;    derr_ff  <= ctl_pkg::DerrNone; kw_ff <= '0;
         run_ff   <= '0;      sline_ff <= LB'(1); scol_ff <= '0;
         line_ff  <= LB'(1);  col_ff   <= '0;
         wptr_ff  <= 2'd0;    rptr_ff  <= 2'd0;   cnt_ff  <= 3'd0;
      end else begin
         if (req_acc) begin
            mode_ff  <= mode_in;  pend_ff  <= pend_in;  acc_ff  <= acc_in;
            ovf_ff   <= ovf_in;   derr_ff  <= derr_in;  kw_ff   <= kw_in;
            run_ff   <= run_in;   sline_ff <= sline_in; scol_ff <= scol_in;
            line_ff  <= line_in;  col_ff   <= col_in;
            wptr_ff  <= wptr_ff + nres;
         end
         if (rsp_acc) rptr_ff <= rptr_ff + 2'd1;
         cnt_ff <= cnt_ff + (req_acc ? {1'b0, nres} : 3'd0) - (rsp_acc ? 3'd1 : 3'd0);
      end
   end

   // queue payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_acc && nres != 2'd0) q_ff[wptr_ff] <= res[0];
      if (req_acc && nres == 2'd2) q_ff[wptr_ff + 2'd1] <= res[1];
   end

   assign rsp_tuser = q_ff[rptr_ff].kind;
   assign rsp_tlast = q_ff[rptr_ff].last_of_step;
   assign rsp_tdata = {5'd0, q_ff[rptr_ff].diag, q_ff[rptr_ff].token_len,
                       q_ff[rptr_ff].token_col, q_ff[rptr_ff].token_line,
                       q_ff[rptr_ff].number_value, q_ff[rptr_ff].punct_char};

   // queue never overfills
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4) else $error("result queue overflow");

   // end of input returns the scanner to idle at line 1, column 0
   a_end_reset: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tdata == 8'd0) |=> (mode_ff == M_IDLE && line_ff == LB'(1) &&
                                          col_ff == CB'(0)))
      else $error("scanner not rewound after end of input");

   // a byte 0 always yields at least the end token, so the queue cannot be empty next
   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tdata == 8'd0) |=> (cnt_ff != 3'd0))
      else $error("end of input produced no token");

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the C token lexer core: directed text plus random C-like source.
`default_nettype none
module testbench;
   import ctl_pkg::*;

   // two-character operator kinds
   localparam logic [5:0] KindInc  = 6'd7;
   localparam logic [5:0] KindArw  = 6'd8;
   localparam logic [5:0] KindDec  = 6'd9;
   localparam logic [5:0] KindLe   = 6'd10;
   localparam logic [5:0] KindShl  = 6'd11;
   localparam logic [5:0] KindGe   = 6'd12;
   localparam logic [5:0] KindShr  = 6'd13;
   localparam logic [5:0] KindEq   = 6'd14;
   localparam logic [5:0] KindLor  = 6'd15;
   localparam logic [5:0] KindLand = 6'd16;
   localparam logic [5:0] KindNe   = 6'd17;
   localparam logic [5:0] KindWhile = KindKwBase + 6'd31;
   localparam int CycleLimit = 3_000_000;

   typedef enum logic [3:0] {
      ScIdle, ScIdent, ScOct, ScDec, ScHex, ScFloat, ScDot, ScOp, ScStr, ScChr, ScBcom, ScLcom
   } scan_state_type;

   typedef struct {
      logic [7:0] src;
      logic       has_exp;
      logic [5:0] kind;
      logic [2:0] diag;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'd0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic [5:0]   rsp_tuser;
   logic         rsp_tlast;

   c_token_lexer_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   // directed text: 0x;0xg 09@.5 while( "a <end>
   dir_row_type dir_rows [] = '{
      '{"0", 0, 0, 0}, '{"x", 0, 0, 0}, '{";", 1, KindError, DiagEmptyHx},
      '{"0", 0, 0, 0}, '{"x", 0, 0, 0}, '{"g", 0, 0, 0}, '{" ", 1, KindError, DiagBadHex},
      '{"0", 0, 0, 0}, '{"9", 0, 0, 0}, '{"@", 1, KindInt, DiagBadOct},
      '{".", 0, 0, 0}, '{"5", 0, 0, 0}, '{" ", 1, KindFloat, DiagNone},
      '{"w", 0, 0, 0}, '{"h", 0, 0, 0}, '{"i", 0, 0, 0}, '{"l", 0, 0, 0}, '{"e", 0, 0, 0},
      '{"(", 1, KindWhile, DiagNone}, '{" ", 0, 0, 0}, '{"\"", 0, 0, 0}, '{"a", 0, 0, 0},
      '{8'd0, 1, KindError, DiagUnterm}
   };

   string kw_names [32] = '{
      "auto", "break", "case", "char", "const", "continue", "default", "do",
      "double", "else", "enum", "extern", "float", "for", "goto", "if",
      "int", "long", "register", "return", "short", "signed", "sizeof", "static",
      "struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"};

   logic [7:0]   src_text [$];
   rsp_item_type token_q [$];
   int           src_ptr = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           accepted = 0;
   int           tokens_checked = 0;
   int           mismatches = 0;
   int           cycles = 0;
   bit           hold_done = 0;

   // scanner copy
   scan_state_type sc_mode;
   logic [7:0]     sc_pend;
   logic [63:0]    sc_acc;
   logic           sc_ovf;
   logic [1:0]     sc_derr;
   logic [7:0]     sc_kw [8];
   logic [11:0]    sc_len;
   logic [15:0]    sc_sline, sc_lcnt;
   logic [11:0]    sc_scol, sc_ccnt;
   int             sc_nres;

   function automatic logic is_dig(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_let(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic logic [5:0] op_pair(logic [7:0] a, logic [7:0] b);
      case (a)
         "+": return b == "+" ? KindInc : KindNone;
         "-": return b == ">" ? KindArw : (b == "-" ? KindDec : KindNone);
         "<": return b == "=" ? KindLe : (b == "<" ? KindShl : KindNone);
         ">": return b == "=" ? KindGe : (b == ">" ? KindShr : KindNone);
         "=": return b == "=" ? KindEq : KindNone;
         "|": return b == "|" ? KindLor : KindNone;
         "&": return b == "&" ? KindLand : KindNone;
         "!": return b == "=" ? KindNe : KindNone;
         default: return KindNone;
      endcase
   endfunction

   function automatic logic [5:0] word_kind();
      logic ok;
      if (sc_len > 12'd8) return KindIdent;
      for (int k = 0; k < 32; k++) begin
         ok = kw_names[k].len() == int'(sc_len);
         for (int i = 0; ok && i < int'(sc_len); i++)
            if (kw_names[k][i] != sc_kw[i]) ok = 0;
         if (ok) return KindKwBase + 6'(k);
      end
      return KindIdent;
   endfunction

   function automatic void add_token(logic [5:0] k, logic [7:0] pc, logic [63:0] v,
                                     logic [2:0] dg);
      rsp_item_type t;
      if (sc_nres >= 2) return;
      t.kind = k; t.punct_char = pc; t.number_value = v; t.token_line = sc_sline;
      t.token_col = sc_scol; t.token_len = sc_len; t.diag = dg; t.last_of_step = 1'b0;
      token_q.push_back(t);
      sc_nres++;
   endfunction

   function automatic void grow_run();
      if (sc_len != LenSat) sc_len++;
   endfunction

   function automatic void scanner_reset();
      sc_mode = ScIdle; sc_pend = 0; sc_acc = 0; sc_ovf = 0; sc_derr = DerrNone;
      foreach (sc_kw[i]) sc_kw[i] = 0;
      sc_len = 0; sc_sline = 1; sc_scol = 0; sc_lcnt = 1; sc_ccnt = 0;
   endfunction

   function automatic void open_token(logic [7:0] b);
      sc_mode = ScIdle; sc_sline = sc_lcnt; sc_scol = sc_ccnt; sc_len = 1;
      sc_acc = 0; sc_ovf = 0; sc_derr = DerrNone; sc_pend = 0;
      if (b == 0) begin
         sc_len = 0;
         add_token(KindEnd, 0, 0, DiagNone);
         sc_lcnt = 1; sc_ccnt = 0;
      end else if (b inside {" ", 8'h09, 8'h0b, 8'h0c, 8'h0a, 8'h0d, "#", "\\"}) begin
         // blanks and ignored characters
      end else if (is_let(b)) begin
         sc_mode = ScIdent; sc_kw[0] = b;
      end else if (b == "0") sc_mode = ScOct;
      else if (is_dig(b)) begin
         sc_mode = ScDec; sc_acc = 64'(b - "0");
      end else if (b == ".") sc_mode = ScDot;
      else if (b == "\"") sc_mode = ScStr;
      else if (b == "'") sc_mode = ScChr;
      else if (b inside {"/", "+", "-", "<", ">", "=", "|", "&", "!"}) begin
         sc_mode = ScOp; sc_pend = b;
      end else if (b inside {";", ",", ":", "*", "~", "%", "^", "?", "[", "]", "{", "}",
                             "(", ")"})
         add_token(KindPunct, b, 0, DiagNone);
      else add_token(KindError, 0, 0, DiagIllegal);
   endfunction

   // advance the scanner copy by one byte and queue the tokens it completes
   function automatic void predict_tokens(logic [7:0] b);
      logic [63:0] d;
      logic [5:0]  k;
      sc_nres = 0;
      case (sc_mode)
         ScIdent:
            if (is_let(b) || is_dig(b)) begin
               if (sc_len < 12'd8) sc_kw[sc_len[2:0]] = b;
               grow_run();
            end else begin
               add_token(word_kind(), 0, 0, DiagNone); open_token(b);
            end
         ScOct:
            if (sc_len == 1 && (b == "x" || b == "X")) begin
               sc_mode = ScHex; grow_run();
            end else if (sc_len == 1 && b == ".") begin
               sc_mode = ScFloat; grow_run();
            end else if (is_dig(b)) begin
               d = 64'(b - "0");
               if (d > 7) sc_derr = DerrOct;
               if (sc_acc[63:61] != 0) sc_ovf = 1; else sc_acc = (sc_acc << 3) + d;
               grow_run();
            end else begin
               add_token(KindInt, 0, sc_acc,
                         sc_derr != DerrNone ? DiagBadOct : (sc_ovf ? DiagOvf : DiagNone));
               open_token(b);
            end
         ScDec:
            if (is_dig(b)) begin
               d = 64'(b - "0");
               if (sc_acc > ({64{1'b1}} - d) / 10) sc_ovf = 1; else sc_acc = sc_acc * 10 + d;
               grow_run();
            end else if (b == ".") begin
               sc_mode = ScFloat; grow_run();
            end else begin
               add_token(KindInt, 0, sc_acc, sc_ovf ? DiagOvf : DiagNone); open_token(b);
            end
         ScHex:
            if (is_let(b) || is_dig(b)) begin
               if (is_dig(b)) d = 64'(b - "0");
               else if (b >= "a" && b <= "f") d = 64'(b - "a" + 10);
               else if (b >= "A" && b <= "F") d = 64'(b - "A" + 10);
               else begin
                  d = {64{1'b1}}; sc_derr = DerrHex;
               end
               if (d != {64{1'b1}}) begin
                  if (sc_acc[63:60] != 0) sc_ovf = 1; else sc_acc = (sc_acc << 4) | d;
               end
               grow_run();
            end else begin
               if (sc_len == 2) add_token(KindError, 0, 0, DiagEmptyHx);
               else if (sc_derr != DerrNone) add_token(KindError, 0, sc_acc, DiagBadHex);
               else add_token(KindInt, 0, sc_acc, sc_ovf ? DiagOvf : DiagNone);
               open_token(b);
            end
         ScFloat:
            if (is_dig(b)) grow_run();
            else begin
               add_token(KindFloat, 0, sc_acc, sc_ovf ? DiagOvf : DiagNone); open_token(b);
            end
         ScDot:
            if (is_dig(b)) begin
               sc_mode = ScFloat; sc_acc = 0; grow_run();
            end else begin
               add_token(KindPunct, ".", 0, DiagNone); open_token(b);
            end
         ScOp:
            if (sc_pend == "/" && b == "*") begin
               sc_mode = ScBcom; sc_pend = 0; grow_run();
            end else if (sc_pend == "/" && b == "/") sc_mode = ScLcom;
            else begin
               k = op_pair(sc_pend, b);
               if (k != KindNone) begin
                  sc_len = 2; add_token(k, 0, 0, DiagNone); sc_mode = ScIdle;
               end else begin
                  add_token(KindPunct, sc_pend, 0, DiagNone); open_token(b);
               end
            end
         ScStr, ScChr:
            if (b == 0) begin
               add_token(KindError, 0, 0, DiagUnterm); open_token(0);
            end else begin
               grow_run();
               if (sc_pend == "\\") sc_pend = 0;
               else if (b == "\\") sc_pend = "\\";
               else if (b == (sc_mode == ScStr ? "\"" : "'")) begin
                  add_token(KindString, 0, 0, DiagNone); sc_mode = ScIdle;
               end
            end
         ScBcom:
            if (b == 0) begin
               add_token(KindError, 0, 0, DiagUnterm); open_token(0);
            end else begin
               grow_run();
               if (sc_pend == "*" && b == "/") sc_mode = ScIdle;
               else sc_pend = (b == "*") ? "*" : 8'd0;
            end
         ScLcom: if (b == 0 || b == 8'h0a) open_token(b);
         default: open_token(b);
      endcase
      if (b == 8'h0a || b == 8'h0d) begin
         if (sc_lcnt != LineSat) sc_lcnt++;
         sc_ccnt = 0;
      end else if (b != 0 && sc_ccnt != ColSat) sc_ccnt++;
      if (sc_nres > 0) token_q[$].last_of_step = 1'b1;
   endfunction

   // source text builders
   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
   endfunction

   function automatic void put_digits(int n, int lo, int hi);
      for (int i = 0; i < n; i++) src_text.push_back(8'($urandom_range(lo, hi)));
   endfunction

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   // one well-formed or broken C fragment with random content
   function automatic void put_fragment();
      string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
      string hexchr = "0123456789abcdefABCDEFgzG_";
      string opchr = "+-<>=|&!/";
      string punch = ";,:*~%^?[]{}().";
      string blanks = " \t\v\f\n\r#\\";
      case ($urandom_range(0, 21))
         0, 1: begin
            src_text.push_back(pick(letters));
            repeat ($urandom_range(0, 10))
               src_text.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range("0", "9"))
                                                          : pick(letters));
         end
         2, 3: put_text(kw_names[$urandom_range(0, 31)]);
         4: begin
            src_text.push_back(8'($urandom_range("1", "9")));
            put_digits($urandom_range(0, 22), "0", "9");
         end
         5: begin
            put_text($urandom_range(0, 1) ? "0x" : "0X");
            repeat ($urandom_range(0, 18))
               src_text.push_back($urandom_range(0, 7) == 0 ? pick(hexchr)
                                                          : hexchr[$urandom_range(0, 21)]);
         end
         6: begin
            src_text.push_back("0");
            put_digits($urandom_range(0, 23), "0", $urandom_range(0, 3) ? "7" : "9");
         end
         7: begin
            if ($urandom_range(0, 1)) put_digits($urandom_range(1, 21), "0", "9");
            src_text.push_back(".");
            put_digits($urandom_range(0, 4), "0", "9");
         end
         8: begin
            src_text.push_back("\"");
            repeat ($urandom_range(0, 12))
               src_text.push_back($urandom_range(0, 5) == 0 ? pick("\\\"\n\r'")
                                                          : 8'($urandom_range(1, 255)));
            src_text.push_back("\"");
         end
         9: begin
            src_text.push_back("'");
            if ($urandom_range(0, 2) == 0) src_text.push_back("\\");
            src_text.push_back(8'($urandom_range(1, 255)));
            src_text.push_back("'");
         end
         10: begin
            put_text("/*");
            repeat ($urandom_range(0, 10))
               src_text.push_back($urandom_range(0, 3) == 0 ? pick("*/\n")
                                                          : 8'($urandom_range(1, 255)));
            put_text($urandom_range(0, 1) ? "*/" : "**/");
         end
         11: begin
            put_text("//");
            repeat ($urandom_range(0, 10)) src_text.push_back(8'($urandom_range(11, 255)));
            src_text.push_back(8'h0a);
         end
         12, 13, 14: begin
            src_text.push_back(pick(opchr));
            src_text.push_back(pick(opchr));
         end
         15, 16: src_text.push_back(pick(punch));
         17: src_text.push_back(pick(blanks));
         18: src_text.push_back(8'($urandom_range(1, 255)));
         19: if ($urandom_range(0, 3) == 0) begin
            // unterminated literal or comment closed by the end byte
            put_text($urandom_range(0, 1) ? "\"ab" : "/* x");
            src_text.push_back(8'd0);
         end
         20: if ($urandom_range(0, 5) == 0) src_text.push_back(8'd0);
         default: put_text(" ");
      endcase
      if ($urandom_range(0, 2) == 0) src_text.push_back(pick(blanks));
   endfunction

   initial begin
      foreach (dir_rows[i]) src_text.push_back(dir_rows[i].src);
      while (src_text.size() < 2000) put_fragment();
      src_text.push_back(8'd0);
      scanner_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // sender: bursts with random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) src_ptr++;
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || src_ptr >= src_text.size()) begin
               req_tvalid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= src_text[src_ptr];
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 3) == 0 ? 400 : $urandom_range(1, 30);
                  gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // receiver: own stall pattern, with one long hold-off to fill the block
   initial begin
      int mode_left, mode;
      mode = 0;
      mode_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!hold_done && accepted > 300) begin
            hold_done = 1;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(5, 80);
         end
         mode_left--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= $urandom_range(0, 7) == 0;
            default: rsp_tready <= (mode_left % 3) != 0;
         endcase
      end
   end

   // predict on each accepted byte; check the directed rows with typed results
   always @(posedge clock) begin
      int first;
      if (!reset && req_tvalid && req_tready) begin
         first = token_q.size();
         predict_tokens(req_tdata);
         if (accepted < dir_rows.size() && dir_rows[accepted].has_exp) begin
            if (token_q.size() == first || token_q[first].kind != dir_rows[accepted].kind ||
                token_q[first].diag != dir_rows[accepted].diag) begin
               mismatches++;
               if (mismatches <= 10) begin
                  if (token_q.size() == first)
                     $display("directed byte %0d: exp kind %0d diag %0d, got no token",
                              accepted, dir_rows[accepted].kind, dir_rows[accepted].diag);
                  else
                     $display("directed byte %0d: exp kind %0d diag %0d, got kind %0d diag %0d",
                              accepted, dir_rows[accepted].kind, dir_rows[accepted].diag,
                              token_q[first].kind, token_q[first].diag);
               end
            end
         end
         accepted++;
      end
   end

   // compare every accepted token with the oldest prediction
   always @(posedge clock) begin
      rsp_item_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.punct_char = rsp_tdata[7:0];
         got.number_value = rsp_tdata[71:8];
         got.token_line = rsp_tdata[87:72];
         got.token_col = rsp_tdata[99:88];
         got.token_len = rsp_tdata[111:100];
         got.diag = rsp_tdata[114:112];
         got.last_of_step = rsp_tlast;
         if (token_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected token: %p", got);
         end else begin
            want = token_q.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10) $display("token %0d mismatch\n  exp %p\n  got %p",
                                              tokens_checked, want, got);
            end
         end
         tokens_checked++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d tokens outstanding", cycles, token_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      @(negedge reset);
      wait (src_ptr >= src_text.size() && !req_tvalid);
      wait (token_q.size() == 0);
      repeat (20) @(posedge clock);
      $display("Covered %0d source bytes and %0d tokens of random C-like text, including",
               accepted, tokens_checked);
      $display("bad and empty literals, unterminated literals and a long output stall.");
      if (mismatches == 0 && token_q.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
rtl/core/ctl_pkg.sv
rtl/core/c_token_lexer_core.sv
tb/sv/testbench.sv
